[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/dfmt_pkg.sv]
// ----------------------------------------------------------------------------
// dfmt_pkg
// Types, ASCII codes and unit text for the decimal frequency formatter.
// ----------------------------------------------------------------------------
package dfmt_pkg;

  localparam int VAL_W      = 32;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 10;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 4;
  localparam int BIT_W      = 5;

  typedef logic [VAL_W-1:0]                 value_t;
  typedef logic [CHAR_W-1:0]                char_t;
  typedef logic [NUM_DIGITS-1:0][3:0]       digit_vec_t;
  typedef logic [IDX_W-1:0]                 idx_t;
  typedef logic [CNT_W-1:0]                 cnt_t;

  localparam char_t ASCII_ZERO  = 7'h30;
  localparam char_t ASCII_POINT = 7'h2E;
  localparam char_t ASCII_SPACE = 7'h20;
  localparam char_t ASCII_K     = 7'h6B;
  localparam char_t ASCII_H     = 7'h48;
  localparam char_t ASCII_Z     = 7'h7A;

  localparam value_t KHZ_MIN    = 32'd1000;
  localparam idx_t   KHZ_BASE   = 4'd3;
  localparam idx_t   FRAC_HI    = 4'd2;
  localparam idx_t   FRAC_LO    = 4'd1;
  localparam logic [2:0] KHZ_LAST = 3'd3;
  localparam logic [2:0] HZ_LAST  = 3'd4;

  function automatic char_t unit_char(input logic khz, input logic [2:0] k);
    char_t c;
    c = ASCII_SPACE;
    if (khz) begin
      case (k)
        3'd0:    c = ASCII_SPACE;
        3'd1:    c = ASCII_K;
        3'd2:    c = ASCII_H;
        3'd3:    c = ASCII_Z;
        default: c = ASCII_SPACE;
      endcase
    end else begin
      case (k)
        3'd0:    c = ASCII_SPACE;
        3'd1:    c = ASCII_H;
        3'd2:    c = ASCII_Z;
        default: c = ASCII_SPACE;
      endcase
    end
    return c;
  endfunction

endpackage

[sv/decimal_frequency_formatter_unit.sv]
// ----------------------------------------------------------------------------
// decimal_frequency_formatter_unit
// Formats a 32-bit value as ASCII text, one character per output request.
// Mode 0 gives the plain decimal number; mode 1 gives a frequency as "N Hz  "
// below 1000 or "K.FF kHz" at 1000 and above. The block takes one request
// at a time: after acceptance a shift-and-add-3 unit converts one bit per
// cycle over all 32 bits, a count state sets the digit count, then one character
// leaves per cycle while the output is not stalled, up to 14 characters.
// MAX_DIGITS caps the digits printed for the number or kilohertz part.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_frequency_formatter_unit #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  dfmt_pkg::value_t      in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dfmt_pkg::char_t       out_char_code,
  output logic                  out_last
);
  import dfmt_pkg::*;

  localparam int   CAP   = (MAX_DIGITS < NUM_DIGITS) ? MAX_DIGITS : NUM_DIGITS;
  localparam cnt_t CAP_C = CNT_W'(CAP);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_COUNT = 3'd2;
  localparam logic [2:0] S_NUM   = 3'd3;
  localparam logic [2:0] S_POINT = 3'd4;
  localparam logic [2:0] S_FRAC  = 3'd5;
  localparam logic [2:0] S_UNIT  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  value_t           sh_r, sh_nxt;
  digit_vec_t       bcd_r, bcd_nxt, bcd_adj;
  logic [4*NUM_DIGITS:0] bcd_shift;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  idx_t             idx_r, idx_nxt;
  cnt_t             k_r, k_nxt;
  logic             op_r, op_nxt;
  logic             khz_r, khz_nxt;
  logic             out_valid_r, out_valid_nxt;
  char_t            out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_acc;
  logic             load;
  cnt_t             nd, cnt;

  assign in_stall      = (state_r != S_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign load          = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  // shift-and-add-3 adjust
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  assign bcd_shift = {bcd_adj, sh_r[VAL_W-1]};

  // significant digit count, capped
  always_comb begin
    cnt_t n;
    n = CNT_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) n = CNT_W'(i + 1);
    end
    nd  = khz_r ? n - cnt_t'(KHZ_BASE) : n;
    cnt = (nd > CAP_C) ? CAP_C : nd;
  end

  always_comb begin
    state_nxt     = state_r;
    sh_nxt        = sh_r;
    bcd_nxt       = bcd_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    op_nxt        = op_r;
    khz_nxt       = khz_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          sh_nxt    = in_value;
          bcd_nxt   = '0;
          bit_nxt   = '0;
          op_nxt    = in_op;
          khz_nxt   = in_op && (in_value >= KHZ_MIN);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = bcd_shift[4*NUM_DIGITS-1:0];
        sh_nxt  = {sh_r[VAL_W-2:0], 1'b0};
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BIT_W'(VAL_W - 1)) state_nxt = S_COUNT;
      end
      S_COUNT: begin
        idx_nxt   = (khz_r ? KHZ_BASE : idx_t'(0)) + idx_t'(cnt) - 1'b1;
        k_nxt     = cnt - 1'b1;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + char_t'(bcd_r[idx_r]);
          out_last_nxt  = 1'b0;
          idx_nxt       = idx_r - 1'b1;
          k_nxt         = k_r - 1'b1;
          if (k_r == '0) begin
            k_nxt = '0;
            if (!op_r) begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end else if (khz_r) begin
              state_nxt = S_POINT;
            end else begin
              state_nxt = S_UNIT;
            end
          end
        end
      end
      S_POINT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_POINT;
          out_last_nxt  = 1'b0;
          idx_nxt       = FRAC_HI;
          state_nxt     = S_FRAC;
        end
      end
      S_FRAC: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + char_t'(bcd_r[idx_r]);
          out_last_nxt  = 1'b0;
          idx_nxt       = FRAC_LO;
          if (idx_r == FRAC_LO) begin
            k_nxt     = '0;
            state_nxt = S_UNIT;
          end
        end
      end
      S_UNIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = unit_char(khz_r, k_r[2:0]);
          out_last_nxt  = (k_r[2:0] == (khz_r ? KHZ_LAST : HZ_LAST));
          k_nxt         = k_r + 1'b1;
          if (out_last_nxt) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sh_r       <= sh_nxt;
    bcd_r      <= bcd_nxt;
    bit_r      <= bit_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    op_r       <= op_nxt;
    khz_r      <= khz_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  `ASSERT_NEXT(a_accept_conv, clk, rst_n, in_valid && !in_stall, state_r == S_CONV)
  `ASSERT_IMPLY(a_frac_idx, clk, rst_n, state_r == S_FRAC, idx_r == FRAC_HI || idx_r == FRAC_LO)
  `ASSERT_NEXT(a_conv_quiet, clk, rst_n, state_r == S_CONV && out_valid_r && out_stall, out_valid_r && $stable(out_char_r))
  `ASSERT_IMPLY(a_last_idle, clk, rst_n, out_valid_r && out_last_r && !$past(out_valid_r && out_last_r) && $past(rst_n), state_r == S_IDLE || state_r == S_CONV)

endmodule
